// ===== rtl/core/size_lane_round_robin_queues_defines.svh =====
// Assertion macros used by the lane queue datapath.
`ifndef SIZE_LANE_ROUND_ROBIN_QUEUES_DEFINES_SVH
`define SIZE_LANE_ROUND_ROBIN_QUEUES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SLRQ_ASSERT_NOW(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLRQ_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/core/slrq_pkg.sv =====
// Shared types and constants of the lane queue block.
package slrq_pkg;

    localparam int NUM_BOUNDS = 4;
    localparam int BOUND_W    = 31;

    typedef logic [BOUND_W-1:0] bound_t;

    localparam bound_t BOUND_RESET [NUM_BOUNDS] = '{
        31'd4096, 31'd16384, 31'd65536, 31'd262144
    };

    typedef enum logic [1:0] {
        KIND_ANNOUNCE = 2'd0,
        KIND_ADVANCE  = 2'd1,
        KIND_WITHDRAW = 2'd2,
        KIND_UNUSED   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE    = 3'd0,
        ST_ADDED   = 3'd1,
        ST_ALREADY = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_BAD     = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        LS_TGT  = 2'd0,
        LS_IN   = 2'd1,
        LS_ZERO = 2'd2
    } lane_src_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_IDX_CLR,
        OP_IDX_INC,
        OP_READ,
        OP_READ0,
        OP_READ_NEXT,
        OP_WRITE_SHIFT,
        OP_WRITE_TAIL,
        OP_HEAD,
        OP_DEC,
        OP_APPEND,
        OP_CLR_CUR,
        OP_WL_FIRST,
        OP_WL_INC,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t       op;
        status_t   code;
        lane_src_t lsrc;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  bad_lane;
        logic  full;
        logic  empty;
        logic  at_end;
        logic  hit;
        logic  last;
        logic  cur_hit;
        logic  wl_is_tgt;
        logic  wl_last;
        logic  out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/core/slrq_datapath.sv =====
// Datapath: lane memory, per-lane counts and current items, result register.
`include "size_lane_round_robin_queues_defines.svh"

module slrq_datapath
    import slrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int LANE_COUNT  = 5,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1),
    parameter int LW          = $clog2(LANE_COUNT)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  dp_cmd_t       cmd,
    output dp_stat_t      stat,
    input  logic          cfg_write,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    input  logic [1:0]    kind,
    input  logic [7:0]    bundle_id,
    input  logic [30:0]   bundle_length,
    input  logic [2:0]    lane,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [2:0]    status,
    output logic [2:0]    lane_used,
    output logic [7:0]    current_id,
    output logic          current_valid,
    output logic [CW-1:0] lane_count
);

    localparam int AW = $clog2(LANE_COUNT * QUEUE_DEPTH);

    logic [7:0]    mem [LANE_COUNT * QUEUE_DEPTH];
    logic [7:0]    rd_reg;

    bound_t        bound_reg [NUM_BOUNDS];
    logic [CW-1:0] count_reg [LANE_COUNT];
    logic [7:0]    cur_reg   [LANE_COUNT];
    logic          curv_reg  [LANE_COUNT];

    kind_t         kind_reg;
    logic [7:0]    id_reg;
    logic [2:0]    lane_in_reg;
    logic [LW-1:0] tgt_reg;
    logic [LW-1:0] wl_reg;
    logic [CW-1:0] idx_reg;
    logic [7:0]    head_reg;
    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [2:0]    lane_used_reg;
    logic [7:0]    current_id_reg;
    logic          current_valid_reg;
    logic [CW-1:0] lane_count_reg;

    logic [2:0]    pick;
    logic [LW-1:0] pick_sat;
    logic [CW-1:0] cnt_w;
    logic [AW-1:0] base;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          we;

    // Lane choice: first bound above the length.
    always_comb
    begin
        if (bundle_length < bound_reg[0])
            pick = 3'd0;
        else if (bundle_length < bound_reg[1])
            pick = 3'd1;
        else if (bundle_length < bound_reg[2])
            pick = 3'd2;
        else if (bundle_length < bound_reg[3])
            pick = 3'd3;
        else
            pick = 3'd4;
        pick_sat = (pick > 3'(LANE_COUNT - 1)) ? LW'(LANE_COUNT - 1) : LW'(pick);
    end

    assign cnt_w = count_reg[wl_reg];
    assign base  = AW'(wl_reg) * AW'(QUEUE_DEPTH);

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.bad_lane  = lane_in_reg > 3'(LANE_COUNT - 1);
        stat.full      = cnt_w == CW'(QUEUE_DEPTH);
        stat.empty     = cnt_w == '0;
        stat.at_end    = idx_reg == cnt_w;
        stat.hit       = rd_reg == id_reg;
        stat.last      = ({1'b0, idx_reg} + (CW+1)'(1)) >= {1'b0, cnt_w};
        stat.cur_hit   = curv_reg[wl_reg] && (cur_reg[wl_reg] == id_reg);
        stat.wl_is_tgt = wl_reg == tgt_reg;
        stat.wl_last   = wl_reg == LW'(LANE_COUNT - 1);
        stat.out_busy  = out_valid_reg && out_stall;
    end

    // Memory port selection.
    always_comb
    begin
        raddr = base + AW'(idx_reg);
        waddr = base + AW'(idx_reg);
        wdata = rd_reg;
        we    = 1'b0;
        case (cmd.op)
            OP_READ0:     raddr = base;
            OP_READ_NEXT: raddr = base + AW'(idx_reg) + AW'(1);
            OP_WRITE_SHIFT:
            begin
                we = 1'b1;
            end
            OP_WRITE_TAIL:
            begin
                we    = 1'b1;
                waddr = base + AW'(cnt_w) - AW'(1);
                wdata = head_reg;
            end
            OP_APPEND:
            begin
                we    = 1'b1;
                waddr = base + AW'(cnt_w);
                wdata = id_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    // Control state: bounds, counts, current items, result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BOUNDS; b++)
                bound_reg[b] <= BOUND_RESET[b];
            for (int l = 0; l < LANE_COUNT; l++)
            begin
                count_reg[l] <= '0;
                cur_reg[l]   <= '0;
                curv_reg[l]  <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                bound_reg[cfg_index] <= cfg_data;
            case (cmd.op)
                OP_DEC:    count_reg[wl_reg] <= cnt_w - CW'(1);
                OP_APPEND: count_reg[wl_reg] <= cnt_w + CW'(1);
                OP_HEAD:
                begin
                    cur_reg[wl_reg]  <= rd_reg;
                    curv_reg[wl_reg] <= 1'b1;
                end
                OP_CLR_CUR:
                begin
                    cur_reg[wl_reg]  <= '0;
                    curv_reg[wl_reg] <= 1'b0;
                end
                default: ;
            endcase
            if (cmd.op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers and result payload.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg    <= kind_t'(kind);
                id_reg      <= bundle_id;
                lane_in_reg <= lane;
                tgt_reg     <= (kind_t'(kind) == KIND_ANNOUNCE) ? pick_sat : LW'(lane);
                wl_reg      <= (kind_t'(kind) == KIND_ANNOUNCE) ? pick_sat : LW'(lane);
            end
            OP_IDX_CLR:     idx_reg <= '0;
            OP_READ0:       idx_reg <= '0;
            OP_IDX_INC:     idx_reg <= idx_reg + CW'(1);
            OP_WRITE_SHIFT: idx_reg <= idx_reg + CW'(1);
            OP_HEAD:        head_reg <= rd_reg;
            OP_WL_FIRST:    wl_reg <= '0;
            OP_WL_INC:      wl_reg <= wl_reg + LW'(1);
            OP_RESULT:
            begin
                status_reg <= cmd.code;
                case (cmd.lsrc)
                    LS_TGT:  lane_used_reg <= 3'(tgt_reg);
                    LS_IN:   lane_used_reg <= lane_in_reg;
                    default: lane_used_reg <= 3'd0;
                endcase
                if (cmd.lsrc == LS_TGT)
                begin
                    current_id_reg    <= curv_reg[tgt_reg] ? cur_reg[tgt_reg] : 8'd0;
                    current_valid_reg <= curv_reg[tgt_reg];
                    lane_count_reg    <= count_reg[tgt_reg];
                end
                else
                begin
                    current_id_reg    <= 8'd0;
                    current_valid_reg <= 1'b0;
                    lane_count_reg    <= '0;
                end
            end
            default: ;
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign lane_used     = lane_used_reg;
    assign current_id    = current_id_reg;
    assign current_valid = current_valid_reg;
    assign lane_count    = lane_count_reg;

    `SLRQ_ASSERT_NEXT(a_result_shown, cmd.op == OP_RESULT, out_valid_reg, "result not shown")
    `SLRQ_ASSERT_NOW(a_shift_in_range, cmd.op == OP_WRITE_SHIFT, !stat.last, "shift past end")
    `SLRQ_ASSERT_NOW(a_append_room, cmd.op == OP_APPEND, !stat.full, "append to full lane")

endmodule

// ===== rtl/core/slrq_ctrl.sv =====
// Controller: sequences search, shift, rotate and result steps.
module slrq_ctrl
    import slrq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_SCAN, S_SCAN_CHK, S_SHIFT, S_SHIFT_WR,
        S_CUR_CHK, S_ADV_START, S_ADV_HEAD, S_WD_DONE,
        S_OTH_FIRST, S_OTH_CHK, S_OTH_NEXT, S_RESULT
    } state_t;

    typedef enum logic [1:0] {
        CTX_ANN, CTX_WD_ONE, CTX_WD_OTHER, CTX_ADV
    } ctx_t;

    state_t    state_reg, state_next;
    ctx_t      ctx_reg, ctx_next;
    logic      shadv_reg, shadv_next;
    status_t   code_reg, code_next;
    lane_src_t lsrc_reg, lsrc_next;

    always_comb
    begin
        state_next = state_reg;
        ctx_next   = ctx_reg;
        shadv_next = shadv_reg;
        code_next  = code_reg;
        lsrc_next  = lsrc_reg;
        cmd.op     = OP_NONE;
        cmd.code   = code_reg;
        cmd.lsrc   = lsrc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_RESULT;
                if (stat.kind == KIND_ANNOUNCE)
                begin
                    if (stat.full)
                    begin
                        code_next = ST_FULL;
                        lsrc_next = LS_TGT;
                    end
                    else
                    begin
                        cmd.op     = OP_IDX_CLR;
                        ctx_next   = CTX_ANN;
                        state_next = S_SCAN;
                    end
                end
                else if (stat.kind == KIND_UNUSED)
                begin
                    code_next = ST_DONE;
                    lsrc_next = LS_ZERO;
                end
                else if (stat.bad_lane)
                begin
                    code_next = ST_BAD;
                    lsrc_next = LS_IN;
                end
                else if (stat.kind == KIND_ADVANCE)
                begin
                    lsrc_next = LS_TGT;
                    ctx_next  = CTX_ADV;
                    if (stat.empty)
                        code_next = ST_EMPTY;
                    else
                        state_next = S_ADV_START;
                end
                else
                begin
                    cmd.op     = OP_IDX_CLR;
                    ctx_next   = CTX_WD_ONE;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.at_end)
                begin
                    if (ctx_reg == CTX_ANN)
                    begin
                        cmd.op     = OP_APPEND;
                        state_next = S_OTH_FIRST;
                    end
                    else
                        state_next = S_CUR_CHK;
                end
                else
                begin
                    cmd.op     = OP_READ;
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (!stat.hit)
                begin
                    cmd.op     = OP_IDX_INC;
                    state_next = S_SCAN;
                end
                else if (ctx_reg == CTX_ANN)
                begin
                    code_next  = ST_ALREADY;
                    lsrc_next  = LS_TGT;
                    state_next = S_RESULT;
                end
                else
                begin
                    shadv_next = 1'b0;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.last)
                begin
                    if (shadv_reg)
                    begin
                        cmd.op     = OP_WRITE_TAIL;
                        state_next = S_WD_DONE;
                    end
                    else
                    begin
                        cmd.op     = OP_DEC;
                        state_next = S_CUR_CHK;
                    end
                end
                else
                begin
                    cmd.op     = OP_READ_NEXT;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.op     = OP_WRITE_SHIFT;
                state_next = S_SHIFT;
            end
            S_CUR_CHK:
            begin
                if (stat.cur_hit)
                begin
                    cmd.op     = OP_CLR_CUR;
                    state_next = S_ADV_START;
                end
                else
                    state_next = S_WD_DONE;
            end
            S_ADV_START:
            begin
                if (stat.empty)
                    state_next = S_WD_DONE;
                else
                begin
                    cmd.op     = OP_READ0;
                    state_next = S_ADV_HEAD;
                end
            end
            S_ADV_HEAD:
            begin
                cmd.op     = OP_HEAD;
                shadv_next = 1'b1;
                state_next = S_SHIFT;
            end
            S_WD_DONE:
            begin
                if (ctx_reg == CTX_WD_OTHER)
                    state_next = S_OTH_NEXT;
                else
                begin
                    code_next  = ST_DONE;
                    lsrc_next  = LS_TGT;
                    state_next = S_RESULT;
                end
            end
            S_OTH_FIRST:
            begin
                cmd.op     = OP_WL_FIRST;
                state_next = S_OTH_CHK;
            end
            S_OTH_CHK:
            begin
                if (stat.wl_is_tgt)
                    state_next = S_OTH_NEXT;
                else
                begin
                    cmd.op     = OP_IDX_CLR;
                    ctx_next   = CTX_WD_OTHER;
                    state_next = S_SCAN;
                end
            end
            S_OTH_NEXT:
            begin
                if (stat.wl_last)
                begin
                    code_next  = ST_ADDED;
                    lsrc_next  = LS_TGT;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = OP_WL_INC;
                    state_next = S_OTH_CHK;
                end
            end
            S_RESULT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ctx_reg   <= CTX_ANN;
            shadv_reg <= 1'b0;
            code_reg  <= ST_DONE;
            lsrc_reg  <= LS_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            ctx_reg   <= ctx_next;
            shadv_reg <= shadv_next;
            code_reg  <= code_next;
            lsrc_reg  <= lsrc_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

// ===== rtl/core/size_lane_round_robin_queues.sv =====
// Top level of the size-sorted lane queues: controller plus datapath.
//
//  channel  direction  beat contents
//  in       input      kind, bundle_id, bundle_length, lane
//  out      output     status, lane_used, current_id, current_valid, lane_count
//  cfg      input      cfg_index, cfg_data (bound registers, write only)
//
// One beat at a time. Search and each one-place shift take a read step, then a check
// or write step, per id, as the lane memory has a registered read. An id sits in one
// lane only, so an announce scans at most 256 ids and rotates at most 256 more.
// Reset clears counts and current items at once; lane memory is never cleared.
// An out stall only holds the last result step; the next beat is taken after it.
module size_lane_round_robin_queues
    import slrq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256,
    parameter int LANE_COUNT  = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  bundle_id,
    input  logic [30:0] bundle_length,
    input  logic [2:0]  lane,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [2:0]  lane_used,
    output logic [7:0]  current_id,
    output logic        current_valid,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] lane_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each beat through search, shift and rotate steps.
    slrq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold lane memory, counts, current items and the result beat.
    slrq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LANE_COUNT  (LANE_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .bundle_id     (bundle_id),
        .bundle_length (bundle_length),
        .lane          (lane),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .lane_used     (lane_used),
        .current_id    (current_id),
        .current_valid (current_valid),
        .lane_count    (lane_count)
    );

endmodule
